@@ rtl/assert_macros.svh @@
// Assertion helpers shared by the checker files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion with an active-low reset that disables it.
`define SINPI_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Same, on the usual clock and reset names.
`define SINPI_CHECK(name, prop, msg) \
  `SINPI_ASSERT(name, clk_i, rst_ni, prop, msg)

`endif

@@ rtl/sinpi_pkg.sv @@
package sinpi_pkg;

  // Signed exponent wide enough for products of subnormal operands
  localparam int unsigned EW = 12;
  typedef logic signed [EW-1:0] exp_t;

  // Register stages inside one multiply-add unit
  localparam int unsigned FMA_LAT = 6;
  localparam int unsigned NUM_OPS = 7;

  localparam logic [31:0] NEG_ZERO    = 32'h8000_0000;
  localparam logic [31:0] EXP_ALL     = 32'h7F80_0000;
  localparam logic [31:0] QUIET_BIT   = 32'h0040_0000;
  localparam logic [31:0] DEFAULT_NAN = 32'h7FC0_0000;

  // Polynomial coefficients, lowest order first
  localparam logic [31:0] COEF [6] = '{
    32'h4049_0FDB, 32'hC0A5_5DE7, 32'h4023_35E3,
    32'hBF19_6966, 32'h3DA8_3C18, 32'hBBF1_83A8
  };

  // Unpacked operand with its significand normalized
  typedef struct packed {
    logic        sign;
    logic        zero;
    logic [23:0] man;
    exp_t        e;
  } unp_t;

  // Data that travels beside the arithmetic pipeline
  typedef struct packed {
    logic        spec;
    logic [31:0] spec_val;
    logic        odd;
    logic [31:0] rf;
    logic [31:0] r2;
  } side_t;

  function automatic logic [4:0] lzc24(input logic [23:0] v);
    logic [4:0] cnt;
    cnt = 5'd24;
    for (int i = 0; i < 24; i++) begin
      if (v[i]) cnt = 5'(23 - i);
    end
    return cnt;
  endfunction

  function automatic logic [5:0] lzc54(input logic [53:0] v);
    logic [5:0] cnt;
    cnt = 6'd54;
    for (int i = 0; i < 54; i++) begin
      if (v[i]) cnt = 6'(53 - i);
    end
    return cnt;
  endfunction

  // Split a single-precision value; significand value is man * 2^e
  function automatic unp_t unpack_f(input logic [31:0] f);
    unp_t        u;
    logic [7:0]  ef;
    logic [23:0] m;
    logic [4:0]  lz;
    ef = f[30:23];
    m  = {ef != 8'd0, f[22:0]};
    lz = lzc24(m);
    u.sign = f[31];
    u.zero = (m == 24'd0);
    u.man  = m << lz;
    u.e    = exp_t'({4'd0, (ef == 8'd0) ? 8'd1 : ef}) - exp_t'(150)
             - exp_t'({7'd0, lz});
    return u;
  endfunction

  // Clamp a shift count to [0, lim]
  function automatic logic [5:0] clamp_shift(input exp_t v, input logic [5:0] lim);
    logic [5:0] r;
    if (v < exp_t'(0)) r = 6'd0;
    else if (v > exp_t'({6'd0, lim})) r = lim;
    else r = v[5:0];
    return r;
  endfunction

  // Right shift that folds every dropped bit into the lowest bit
  function automatic logic [53:0] align_shift(input logic [53:0] v, input logic [5:0] k);
    logic [107:0] w;
    w = {v, 54'd0} >> k;
    return {w[107:55], w[54] | (|w[53:0])};
  endfunction

endpackage

@@ rtl/sinpi_fma.sv @@
module sinpi_fma
  import sinpi_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  input  logic [31:0] c_i,
  output logic [31:0] res_o
);

  // Stage 1: unpack and normalize the three operands
  unp_t ua, ub, uc;
  assign ua = unpack_f(a_i);
  assign ub = unpack_f(b_i);
  assign uc = unpack_f(c_i);

  logic [23:0] s1_ma_q, s1_mb_q, s1_mc_q;
  exp_t        s1_ep_q, s1_ec_q;
  logic        s1_sp_q, s1_pz_q, s1_sc_q, s1_cz_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s1_ma_q <= ua.man;
      s1_mb_q <= ub.man;
      s1_mc_q <= uc.man;
      s1_ep_q <= ua.e + ub.e;
      s1_ec_q <= uc.e;
      s1_sp_q <= ua.sign ^ ub.sign;
      s1_pz_q <= ua.zero | ub.zero;
      s1_sc_q <= uc.sign;
      s1_cz_q <= uc.zero;
    end
  end

  // Stage 2: multiply significands, pick the frame top exponent
  logic [47:0] pm;
  exp_t        tp, tc, tt;
  assign pm = 48'(s1_ma_q) * 48'(s1_mb_q);
  assign tp = s1_ep_q + exp_t'(48);
  assign tc = s1_ec_q + exp_t'(24);

  always_comb begin
    if (s1_pz_q) tt = tc;
    else if (s1_cz_q) tt = tp;
    else tt = (tp > tc) ? tp : tc;
  end

  logic [47:0] s2_pm_q;
  logic [23:0] s2_mc_q;
  exp_t        s2_t_q;
  logic [5:0]  s2_kp_q, s2_kc_q;
  logic        s2_sp_q, s2_sc_q, s2_zs_q, s2_sub_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_pm_q  <= pm;
      s2_mc_q  <= s1_mc_q;
      s2_t_q   <= tt;
      s2_kp_q  <= clamp_shift(tt - tp, 6'd54);
      s2_kc_q  <= clamp_shift(tt - tc, 6'd54);
      s2_sp_q  <= s1_sp_q;
      s2_sc_q  <= s1_sc_q;
      s2_zs_q  <= s1_sp_q & s1_sc_q;
      s2_sub_q <= s1_sp_q ^ s1_sc_q;
    end
  end

  // Stage 3: align both terms in the frame, collect sticky bits
  logic [53:0] s3_a_q, s3_b_q;
  exp_t        s3_t_q;
  logic        s3_sp_q, s3_sc_q, s3_zs_q, s3_sub_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_a_q   <= align_shift({1'b0, s2_pm_q, 5'd0}, s2_kp_q);
      s3_b_q   <= align_shift({1'b0, s2_mc_q, 29'd0}, s2_kc_q);
      s3_t_q   <= s2_t_q;
      s3_sp_q  <= s2_sp_q;
      s3_sc_q  <= s2_sc_q;
      s3_zs_q  <= s2_zs_q;
      s3_sub_q <= s2_sub_q;
    end
  end

  // Stage 4: add or subtract magnitudes
  logic [54:0] diff, ndiff;
  logic [53:0] s4_s_d;
  logic        s4_sgn_d;
  assign diff  = {1'b0, s3_a_q} - {1'b0, s3_b_q};
  assign ndiff = 55'd0 - diff;

  always_comb begin
    if (!s3_sub_q) begin
      s4_s_d   = s3_a_q + s3_b_q;
      s4_sgn_d = s3_sp_q;
    end else if (diff[54]) begin
      s4_s_d   = ndiff[53:0];
      s4_sgn_d = s3_sc_q;
    end else begin
      s4_s_d   = diff[53:0];
      s4_sgn_d = s3_sp_q;
    end
  end

  logic [53:0] s4_s_q;
  exp_t        s4_t_q;
  logic        s4_sgn_q, s4_zs_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_s_q   <= s4_s_d;
      s4_t_q   <= s3_t_q;
      s4_sgn_q <= s4_sgn_d;
      s4_zs_q  <= s3_zs_q;
    end
  end

  // Stage 5: leading zero count and result exponent
  logic [5:0] lz;
  logic       szero;
  assign lz    = lzc54(s4_s_q);
  assign szero = (s4_s_q == 54'd0);

  logic [53:0] s5_s_q;
  logic [5:0]  s5_lz_q;
  exp_t        s5_be_q;
  logic        s5_zero_q, s5_sgn_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_s_q    <= s4_s_q;
      s5_lz_q   <= lz;
      s5_be_q   <= s4_t_q + exp_t'(127) - exp_t'({6'd0, lz});
      s5_zero_q <= szero;
      s5_sgn_q  <= szero ? s4_zs_q : s4_sgn_q;
    end
  end

  // Stage 6: normalize, denormalize if tiny, round to nearest even, pack
  logic [53:0] nrm;
  logic        is_norm;
  logic [5:0]  rs;
  logic [7:0]  ef;
  logic [79:0] w80;
  logic [23:0] mant;
  logic        rnd, stk, inc;
  logic [30:0] pk;
  logic [31:0] res_q;

  assign nrm     = s5_s_q << s5_lz_q;
  assign is_norm = (s5_be_q > exp_t'(0));
  assign rs      = is_norm ? 6'd0 : clamp_shift(exp_t'(1) - s5_be_q, 6'd26);
  assign ef      = is_norm ? s5_be_q[7:0] : 8'd0;
  assign w80     = {nrm, 26'd0} >> rs;
  assign mant    = w80[79:56];
  assign rnd     = w80[55];
  assign stk     = |w80[54:0];
  assign inc     = rnd & (stk | mant[0]);
  assign pk      = {ef, mant[22:0]} + 31'(inc);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      res_q <= s5_zero_q ? {s5_sgn_q, 31'd0} : {s5_sgn_q, pk};
    end
  end

  assign res_o = res_q;

endmodule

@@ rtl/sinpi_float32_unit_top.sv @@
// Throughput: one request per cycle unless the output stalls; the argument split takes two
// stages, then seven six-stage multiply-add units run in a chain, then one output register.
// A stalled output holds the whole pipeline in place.
// Reset clears only the valid bits; data registers are not reset.
module sinpi_float32_unit_top
  import sinpi_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic [31:0] x_bits_i,
  input  logic        lane_enable_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [31:0] result_bits_o
);

  localparam int unsigned SIDE_LAST = NUM_OPS * FMA_LAT;

  logic en;
  logic out_valid_q;
  logic [31:0] out_bits_q;

  // Advance everything unless a finished result is waiting
  assign en         = !out_valid_q || out_ready_i;
  assign in_ready_o = en;

  // Stage R1: special cases, round to nearest integer, remainder
  logic [30:0] ax;
  logic [7:0]  ex;
  logic [23:0] mx;
  logic [4:0]  kk;
  logic [24:0] half, nn;
  logic [25:0] nk, dd, dneg;
  logic        r1_spec_d, r1_odd_d, r1_red_d, r1_sgn_d;
  logic [31:0] r1_sval_d, r1_pass_d;
  logic [23:0] r1_mag_d;

  assign ax   = x_bits_i[30:0];
  assign ex   = x_bits_i[30:23];
  assign mx   = {1'b1, x_bits_i[22:0]};
  assign kk   = 5'(8'd150 - ex);
  assign half = 25'd1 << (kk - 5'd1);
  assign nn   = ({1'b0, mx} + half) >> kk;
  assign nk   = {1'b0, nn} << kk;
  assign dd   = {2'd0, mx} - nk;
  assign dneg = 26'd0 - dd;

  always_comb begin
    r1_spec_d = !lane_enable_i || ({1'b0, ax} >= EXP_ALL);
    if (!lane_enable_i) r1_sval_d = 32'd0;
    else if ({1'b0, ax} > EXP_ALL) r1_sval_d = x_bits_i | QUIET_BIT;
    else r1_sval_d = DEFAULT_NAN;

    r1_odd_d  = 1'b0;
    r1_red_d  = 1'b0;
    r1_pass_d = 32'd0;
    r1_sgn_d  = x_bits_i[31] ^ dd[25];
    r1_mag_d  = dd[25] ? dneg[23:0] : dd[23:0];
    if (ex <= 8'd125) begin
      // below one half: remainder is the argument itself
      r1_pass_d = (ax == 31'd0) ? 32'd0 : x_bits_i;
    end else if (ex <= 8'd149) begin
      r1_red_d = 1'b1;
      r1_odd_d = nn[0];
    end else if (ex == 8'd150) begin
      r1_odd_d = mx[0];
    end
  end

  logic        r1_vld_q;
  logic        r1_spec_q, r1_odd_q, r1_red_q, r1_sgn_q;
  logic [31:0] r1_sval_q, r1_pass_q;
  logic [23:0] r1_mag_q;
  logic [4:0]  r1_k_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      r1_vld_q <= 1'b0;
    end else if (en) begin
      r1_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      r1_spec_q <= r1_spec_d;
      r1_sval_q <= r1_sval_d;
      r1_odd_q  <= r1_odd_d;
      r1_red_q  <= r1_red_d;
      r1_pass_q <= r1_pass_d;
      r1_sgn_q  <= r1_sgn_d;
      r1_mag_q  <= r1_mag_d;
      r1_k_q    <= kk;
    end
  end

  // Stage R2: pack the remainder as single precision
  logic [4:0]  rlz;
  logic [23:0] rmn;
  logic [7:0]  rexp;
  side_t       side0_d;

  assign rlz  = lzc24(r1_mag_q);
  assign rmn  = r1_mag_q << rlz;
  assign rexp = 8'd150 - {3'd0, rlz} - {3'd0, r1_k_q};

  always_comb begin
    side0_d.spec     = r1_spec_q;
    side0_d.spec_val = r1_sval_q;
    side0_d.odd      = r1_odd_q;
    side0_d.r2       = 32'd0;
    if (!r1_red_q) side0_d.rf = r1_pass_q;
    else if (r1_mag_q == 24'd0) side0_d.rf = 32'd0;
    else side0_d.rf = {r1_sgn_q, rexp, rmn[22:0]};
  end

  // Side data and valid bits travel beside the multiply-add chain
  side_t                side_q [0:SIDE_LAST];
  side_t                side_d [1:SIDE_LAST];
  logic [SIDE_LAST:0]   vld_q, vld_d;
  logic [31:0]          fa [NUM_OPS];
  logic [31:0]          fb [NUM_OPS];
  logic [31:0]          fc [NUM_OPS];
  logic [31:0]          fy [NUM_OPS];

  always_comb begin
    for (int j = 1; j <= SIDE_LAST; j++) begin
      side_d[j] = side_q[j-1];
    end
    // capture r*r as it leaves the first unit
    side_d[FMA_LAT+1].r2 = fy[0];
  end

  assign vld_d = {vld_q[SIDE_LAST-1:0], r1_vld_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_q[0] <= side0_d;
      for (int j = 1; j <= SIDE_LAST; j++) begin
        side_q[j] <= side_d[j];
      end
    end
  end

  // Operands: r*r, then Horner steps, then the final product with r
  always_comb begin
    fa[0] = side_q[0].rf;
    fb[0] = side_q[0].rf;
    fc[0] = NEG_ZERO;
    fa[1] = fy[0];
    fb[1] = COEF[5];
    fc[1] = COEF[4];
    for (int i = 2; i <= 5; i++) begin
      fa[i] = side_q[FMA_LAT*i].r2;
      fb[i] = fy[i-1];
      fc[i] = COEF[5-i];
    end
    fa[6] = fy[5];
    fb[6] = side_q[FMA_LAT*6].rf;
    fc[6] = NEG_ZERO;
  end

  for (genvar g = 0; g < NUM_OPS; g++) begin : g_fma
    sinpi_fma u_fma (
      .clk_i (clk_i),
      .en_i  (en),
      .a_i   (fa[g]),
      .b_i   (fb[g]),
      .c_i   (fc[g]),
      .res_o (fy[g])
    );
  end

  // Output register: apply the parity of n, or the special value
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= vld_q[SIDE_LAST];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_bits_q <= side_q[SIDE_LAST].spec ? side_q[SIDE_LAST].spec_val
                  : (fy[NUM_OPS-1] ^ {side_q[SIDE_LAST].odd, 31'd0});
    end
  end

  assign out_valid_o   = out_valid_q;
  assign result_bits_o = out_bits_q;

endmodule

@@ rtl/sinpi_checker.sv @@
`include "assert_macros.svh"

module sinpi_checker (
  input logic clk_i,
  input logic rst_ni,
  input logic in_ready_i,
  input logic out_valid_i,
  input logic out_ready_i
);

  // Hold a result until it is taken
  `SINPI_CHECK(a_out_hold, out_valid_i && !out_ready_i |=> out_valid_i, "result dropped while stalled")

  // Take a request whenever the output is empty or being taken
  `SINPI_CHECK(a_ready_rule, in_ready_i == (!out_valid_i || out_ready_i), "ready does not follow output state")

  // Raise a result only after the pipeline advanced
  `SINPI_CHECK(a_rise_adv, $rose(out_valid_i) |-> $past(in_ready_i), "result appeared during a stall")

endmodule

bind sinpi_float32_unit_top sinpi_checker u_sinpi_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (in_ready_o),
  .out_valid_i (out_valid_o),
  .out_ready_i (out_ready_i)
);

@@ tb/sinpi_float32_unit_top_test.sv @@
`timescale 1ns / 100ps

module sinpi_float32_unit_top_test;
  import sinpi_pkg::*;

  localparam int unsigned IDLE_PCT   = 29;
  localparam int unsigned STALL_MAX  = 2000;
  localparam int unsigned DRAIN_WAIT = 80;
  localparam int unsigned NUM_RANDOM = 650;
  // no-idle window, counted in accepted requests / results
  localparam int unsigned CALM_LO    = 300;
  localparam int unsigned CALM_HI    = 400;

  typedef struct {
    logic [31:0] x;
    logic        en;
  } request_t;

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_ready_o;
  logic [31:0] x_bits_i;
  logic        lane_enable_i;
  logic        out_valid_o;
  logic        out_ready_i;
  logic [31:0] result_bits_o;

  request_t    pending_q[$];
  logic [31:0] sinpi_expected_q[$];
  int unsigned n_mismatch = 0;
  int unsigned n_requests = 0;
  int unsigned n_results  = 0;
  int unsigned n_disabled = 0;
  int unsigned n_special  = 0;
  int unsigned stall_cnt  = 0;

  sinpi_float32_unit_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .x_bits_i     (x_bits_i),
    .lane_enable_i(lane_enable_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .result_bits_o(result_bits_o)
  );

  // 10 ns clock
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Widen a single-precision pattern to a real exactly
  function automatic real sp_to_real(input logic [31:0] b);
    logic [63:0] d;
    logic [22:0] m;
    int          p;
    m = b[22:0];
    d = '0;
    d[63] = b[31];
    if (b[30:23] != 8'd0) begin
      d[62:52] = 11'(int'(b[30:23]) - 127 + 1023);
      d[51:0]  = {m, 29'd0};
    end else if (m != 23'd0) begin
      p = 0;
      for (int i = 0; i < 23; i++) begin
        if (m[i]) p = i;
      end
      d[62:52] = 11'(p - 149 + 1023);
      d[51:0]  = 52'(64'(m) << (52 - p));
    end
    return $bitstoreal(d);
  endfunction

  // Round a real to single precision, nearest even, subnormals kept
  function automatic logic [31:0] real_to_sp(input real v);
    logic [63:0] d;
    logic [63:0] sig;
    logic [63:0] kept;
    logic [63:0] rem;
    logic [63:0] half;
    logic [31:0] b;
    int          u;
    int          sh;
    d = $realtobits(v);
    if (d[62:52] == 11'd0) return {d[63], 31'd0};
    u   = int'(d[62:52]) - 1023;
    sig = {11'd0, 1'b1, d[51:0]};
    sh  = (u >= -126) ? 29 : 29 + (-126 - u);
    if (sh >= 60) return {d[63], 31'd0};
    kept = sig >> sh;
    rem  = sig & ((64'd1 << sh) - 64'd1);
    half = 64'd1 << (sh - 1);
    if (rem > half || (rem == half && kept[0])) kept = kept + 64'd1;
    if (u >= -126) b = 32'((u + 126) << 23) + kept[31:0];
    else b = kept[31:0];
    b[31] = d[63];
    return b;
  endfunction

  function automatic logic [31:0] sp_mul(input logic [31:0] a, input logic [31:0] b);
    return real_to_sp(sp_to_real(a) * sp_to_real(b));
  endfunction

  // a*b + c with one rounding: sum in double rounded to odd, then to single
  function automatic logic [31:0] sp_fma(input logic [31:0] a, input logic [31:0] b,
                                         input logic [31:0] c);
    real         p, dc, s, bv, e;
    logic [63:0] sb;
    p  = sp_to_real(a) * sp_to_real(b);
    dc = sp_to_real(c);
    s  = p + dc;
    bv = s - p;
    e  = (p - (s - bv)) + (dc - bv);
    if (e != 0.0) begin
      sb = $realtobits(s);
      if (!sb[0]) begin
        sb = ((e > 0.0) == (s > 0.0)) ? sb + 64'd1 : sb - 64'd1;
        s  = $bitstoreal(sb);
      end
    end
    return real_to_sp(s);
  endfunction

  function automatic logic [31:0] sinpi_predict(input logic [31:0] xb, input logic en);
    logic [31:0] ax;
    logic [31:0] rf, r2, y;
    logic        odd;
    real         a, rm, r;
    int          n;
    ax  = xb & 32'h7FFF_FFFF;
    odd = 1'b0;
    r   = 0.0;
    if (!en) return 32'd0;
    if (ax > EXP_ALL) return xb | QUIET_BIT;
    if (ax == EXP_ALL) return DEFAULT_NAN;
    a = sp_to_real(ax);
    if (ax < 32'h4B00_0000) begin
      // nearest integer, ties away from zero, on the magnitude
      n   = $rtoi(a + 0.5);
      rm  = a - real'(n);
      odd = n[0];
      if (rm != 0.0) r = xb[31] ? -rm : rm;
    end else if (ax < 32'h4F00_0000) begin
      n   = $rtoi(a);
      odd = n[0];
    end
    rf = real_to_sp(r);
    r2 = sp_mul(rf, rf);
    y  = sp_fma(r2, COEF[5], COEF[4]);
    for (int k = 3; k >= 0; k--) y = sp_fma(r2, y, COEF[k]);
    y = sp_mul(y, rf);
    return y ^ {odd, 31'd0};
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: %s: got %08h, want %08h", $time, what, got, want);
    n_mismatch++;
  endtask

  function automatic logic [31:0] random_arg();
    int unsigned pick;
    logic [31:0] b;
    pick = $urandom_range(99);
    b    = $urandom;
    if (pick < 45) begin
      // moderate magnitudes, where the polynomial does the work
      b[30:23] = 8'($urandom_range(100, 131));
    end else if (pick < 65) begin
      // integers and half-integers
      b = real_to_sp(real'(int'($urandom_range(0, 4000)) - 2000) / 2.0);
    end else if (pick < 72) begin
      // near and past the integer-only ranges
      b[30:23] = 8'($urandom_range(148, 160));
    end else if (pick < 76) begin
      b[30:23] = 8'd0;
    end else if (pick < 80) begin
      b[30:23] = 8'hFF;
      if ($urandom_range(1)) b[22:0] = '0;
    end
    return b;
  endfunction

  // Drive requests from the pending queue
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i    <= 1'b0;
      x_bits_i      <= '0;
      lane_enable_i <= 1'b0;
    end else if (!in_valid_i || in_ready_o) begin
      if (pending_q.size() != 0 &&
          ((n_requests >= CALM_LO && n_requests < CALM_HI) ||
           $urandom_range(99) >= IDLE_PCT)) begin
        request_t req;
        req = pending_q.pop_front();
        in_valid_i    <= 1'b1;
        x_bits_i      <= req.x;
        lane_enable_i <= req.en;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Stall the output at random
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= (n_results >= CALM_LO && n_results < CALM_HI) ||
                     ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // Predict accepted requests, check accepted results, watch for a hang
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) begin
        sinpi_expected_q.push_back(sinpi_predict(x_bits_i, lane_enable_i));
        n_requests++;
        if (!lane_enable_i) n_disabled++;
        else if (x_bits_i[30:23] == 8'hFF) n_special++;
      end
      if (out_valid_o && out_ready_i) begin
        n_results++;
        if (sinpi_expected_q.size() == 0) begin
          report_mismatch("unexpected result", result_bits_o, 32'd0);
        end else begin
          logic [31:0] want;
          want = sinpi_expected_q.pop_front();
          if (result_bits_o !== want) report_mismatch("result_bits", result_bits_o, want);
        end
      end
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        stall_cnt <= 0;
      end else if (stall_cnt + 1 >= STALL_MAX) begin
        $display("Watchdog expired after %0d idle cycles", STALL_MAX);
        $display("Mismatches found");
        $finish;
      end else begin
        stall_cnt <= stall_cnt + 1;
      end
    end
  end

  initial begin
    request_t    req;
    logic [31:0] directed[$];
    rst_ni = 1'b0;

    // zeros, ties, integers, quiet and signaling NaNs, infinities, big and tiny values
    directed = '{32'h0000_0000, 32'h8000_0000, 32'h3F00_0000, 32'hBF00_0000,
                 32'h3FC0_0000, 32'h4020_0000, 32'h3F80_0000, 32'hC000_0000,
                 32'h3E80_0000, 32'hBEAA_AAAB, 32'h4B00_0000, 32'h4B00_0001,
                 32'h4EFF_FFFF, 32'hCF00_0000, 32'h7F7F_FFFF, 32'h0000_0001,
                 32'h807F_FFFF, 32'h7F80_0000, 32'hFF80_0000, 32'h7FC0_0000,
                 32'h7F80_0001, 32'hFFBF_FFFF, 32'h4AFF_FFFF, 32'h3EFF_FFFF};
    foreach (directed[i]) begin
      req.x  = directed[i];
      req.en = 1'b1;
      pending_q.push_back(req);
    end
    req.x  = 32'h3E80_0000;
    req.en = 1'b0;
    pending_q.push_back(req);
    for (int i = 0; i < NUM_RANDOM; i++) begin
      req.x  = random_arg();
      req.en = ($urandom_range(99) >= 8);
      pending_q.push_back(req);
    end

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // drain, then give the pipeline time to show anything extra
    while (pending_q.size() != 0 || in_valid_i || sinpi_expected_q.size() != 0)
      @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    if (sinpi_expected_q.size() != 0) begin
      $display("%0d results never arrived", sinpi_expected_q.size());
      n_mismatch++;
    end
    $display("Sent %0d arguments (%0d on disabled lanes, %0d infinite or NaN), checked %0d results",
             n_requests, n_disabled, n_special, n_results);
    if (n_mismatch == 0) begin
      $display("No mismatches found");
    end else begin
      $display("%0d errors", n_mismatch);
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
